// ===== rtl/swurp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swurp_pkg
// Shared types and constants of the single-wire uart register poller: the
// configuration register indexes, the configuration bundle and the per-tick
// result bundle.
// ----------------------------------------------------------------------------
package swurp_pkg;

    localparam int unsigned C_MAX_ADDRESSES = 16;
    localparam int unsigned C_REPLY_BYTES   = 8;
    localparam int unsigned C_LIST_W        = 56;
    localparam int unsigned C_CFG_IDX_W     = 3;

    localparam logic [7:0] C_SYNC_BYTE  = 8'h05;
    localparam logic [7:0] C_CRC_POLY   = 8'h07;
    localparam logic [3:0] C_FRAME_BITS = 4'd10;
    localparam logic [3:0] C_STOP_BIT   = 4'd9;
    localparam logic [2:0] C_LAST_REQ   = 3'd3;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_ADDR_LIST_LOW  = 3'd0,
        REG_ADDR_LIST_HIGH = 3'd1,
        REG_LIST_LENGTH    = 3'd2,
        REG_BIT_PERIOD     = 3'd3,
        REG_GAP_TICKS      = 3'd4,
        REG_NODE_ADDRESS   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [C_LIST_W-1:0] addr_list_low;
        logic [C_LIST_W-1:0] addr_list_high;
        logic [4:0]          list_length;
        logic [7:0]          bit_period_ticks;
        logic [7:0]          gap_ticks;
        logic [7:0]          node_address;
    } t_cfg;

    typedef struct packed {
        logic       line_drive_enable;
        logic       line_level;
        logic       rx_byte_valid;
        logic [7:0] rx_byte;
        logic       reply_done;
        logic       sweep_done;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/swurp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swurp_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module swurp_cfg
    import swurp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [C_LIST_W-1:0]    i_cfg_data,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.addr_list_low    <= 56'd63542318014824576;
            r_cfg.addr_list_high   <= 56'd14705;
            r_cfg.list_length      <= 5'd10;
            r_cfg.bit_period_ticks <= 8'd3;
            r_cfg.gap_ticks        <= 8'd255;
            r_cfg.node_address     <= 8'd0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ADDR_LIST_LOW:  r_cfg.addr_list_low    <= i_cfg_data;
                REG_ADDR_LIST_HIGH: r_cfg.addr_list_high   <= i_cfg_data;
                REG_LIST_LENGTH:    r_cfg.list_length      <= i_cfg_data[4:0];
                REG_BIT_PERIOD:     r_cfg.bit_period_ticks <= i_cfg_data[7:0];
                REG_GAP_TICKS:      r_cfg.gap_ticks        <= i_cfg_data[7:0];
                REG_NODE_ADDRESS:   r_cfg.node_address     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/swurp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swurp_core
// Poller state and its one-tick next-state logic: request framing with
// crc-8, reply sampling on the bit grid, gap timing and list walking.
// ----------------------------------------------------------------------------
module swurp_core
    import swurp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_tick,
    input  wire logic i_sample,
    input  wire t_cfg i_cfg,
    output t_result   o_result
);

    logic       r_rx_phase, n_rx_phase;
    logic [2:0] r_byte_cnt, n_byte_cnt;
    logic [3:0] r_bit_cnt,  n_bit_cnt;
    logic [7:0] r_crc,      n_crc;
    logic [7:0] r_div,      n_div;
    logic       r_await,    n_await;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [7:0] r_gap,      n_gap;
    logic [3:0] r_pos,      n_pos;
    logic       r_drv_en,   n_drv_en;
    logic       r_drv_lvl,  n_drv_lvl;

    logic [7:0]   w_period;
    logic [4:0]   w_active_len;
    logic [111:0] w_list;
    logic [6:0]   w_entry_base;
    logic [6:0]   w_entry;
    logic [7:0]   w_data;
    logic [2:0]   w_bit_idx;
    logic         w_bit;
    logic [7:0]   w_div_inc;
    logic [7:0]   w_div_adv;
    logic [3:0]   w_bit_inc;
    t_result      w_res;

    assign w_period     = (i_cfg.bit_period_ticks == 8'd0) ? 8'd1 : i_cfg.bit_period_ticks;
    assign w_active_len = (i_cfg.list_length == 5'd0) ? 5'd1 :
                          (i_cfg.list_length > 5'(C_MAX_ADDRESSES)) ? 5'(C_MAX_ADDRESSES) :
                          i_cfg.list_length;
    assign w_list       = {i_cfg.addr_list_high, i_cfg.addr_list_low};
    assign w_entry_base = 7'(r_pos) * 7'd7;
    assign w_entry      = w_list[w_entry_base +: 7];
    assign w_bit_idx    = 3'(r_bit_cnt - 4'd1);
    assign w_div_inc    = r_div + 8'd1;
    assign w_div_adv    = (w_div_inc >= w_period) ? 8'd0 : w_div_inc;
    assign w_bit_inc    = r_bit_cnt + 4'd1;

    always_comb begin
        case (r_byte_cnt)
            3'd0:    w_data = C_SYNC_BYTE;
            3'd1:    w_data = i_cfg.node_address;
            3'd2:    w_data = {1'b0, w_entry};
            default: w_data = r_crc;
        endcase
        if (r_bit_cnt == 4'd0) begin
            w_bit = 1'b0;
        end else if (r_bit_cnt >= C_STOP_BIT) begin
            w_bit = 1'b1;
        end else begin
            w_bit = w_data[w_bit_idx];
        end
    end

    always_comb begin
        n_rx_phase = r_rx_phase;
        n_byte_cnt = r_byte_cnt;
        n_bit_cnt  = r_bit_cnt;
        n_crc      = r_crc;
        n_div      = r_div;
        n_await    = r_await;
        n_rx_shift = r_rx_shift;
        n_gap      = r_gap;
        n_pos      = r_pos;
        n_drv_en   = r_drv_en;
        n_drv_lvl  = r_drv_lvl;
        w_res      = '0;

        if (r_gap != 8'd0) begin
            n_gap = r_gap - 8'd1;
        end else if (!r_rx_phase) begin
            // request transmission
            n_drv_en = 1'b1;
            n_div    = w_div_adv;
            if (r_div == 8'd0) begin
                n_drv_lvl = w_bit;
                if (r_bit_cnt != 4'd0 && r_bit_cnt < C_STOP_BIT && r_byte_cnt <= 3'd2) begin
                    n_crc = {r_crc[6:0], 1'b0} ^ ((r_crc[7] ^ w_bit) ? C_CRC_POLY : 8'd0);
                end
                n_bit_cnt = w_bit_inc;
                if (w_bit_inc >= C_FRAME_BITS) begin
                    n_bit_cnt = 4'd0;
                    if (r_byte_cnt >= C_LAST_REQ) begin
                        n_crc      = 8'd0;
                        n_rx_phase = 1'b1;
                        n_await    = 1'b1;
                        n_rx_shift = 8'd0;
                        n_byte_cnt = 3'd0;
                    end else begin
                        n_byte_cnt = r_byte_cnt + 3'd1;
                    end
                end
            end
        end else begin
            // reply reception
            n_drv_en = 1'b0;
            if (r_await) begin
                if (!i_sample) begin
                    n_await = 1'b0;
                    n_div   = 8'd0;
                end
            end else begin
                n_div = w_div_adv;
                if (r_div == 8'd0) begin
                    if (r_bit_cnt == 4'd0) begin
                        n_rx_shift = 8'd0;
                    end else if (r_bit_cnt >= C_STOP_BIT) begin
                        w_res.rx_byte_valid = 1'b1;
                        w_res.rx_byte       = r_rx_shift;
                    end else begin
                        n_rx_shift = {i_sample, r_rx_shift[7:1]};
                    end
                    n_bit_cnt = w_bit_inc;
                    if (w_bit_inc >= C_FRAME_BITS) begin
                        n_bit_cnt = 4'd0;
                        if (r_byte_cnt >= 3'(C_REPLY_BYTES - 1)) begin
                            w_res.reply_done = 1'b1;
                            n_rx_phase = 1'b0;
                            n_byte_cnt = 3'd0;
                            n_div      = 8'd0;
                            n_gap      = i_cfg.gap_ticks;
                            if (5'(r_pos) + 5'd1 >= w_active_len) begin
                                n_pos            = 4'd0;
                                w_res.sweep_done = 1'b1;
                            end else begin
                                n_pos = r_pos + 4'd1;
                            end
                        end else begin
                            n_byte_cnt = r_byte_cnt + 3'd1;
                        end
                    end
                end
            end
        end
        w_res.line_drive_enable = n_drv_en;
        w_res.line_level        = n_drv_lvl;
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_phase <= 1'b0;
            r_byte_cnt <= 3'd0;
            r_bit_cnt  <= 4'd0;
            r_crc      <= 8'd0;
            r_div      <= 8'd0;
            r_await    <= 1'b0;
            r_rx_shift <= 8'd0;
            r_gap      <= 8'd0;
            r_pos      <= 4'd0;
            r_drv_en   <= 1'b0;
            r_drv_lvl  <= 1'b0;
        end else if (i_tick) begin
            r_rx_phase <= n_rx_phase;
            r_byte_cnt <= n_byte_cnt;
            r_bit_cnt  <= n_bit_cnt;
            r_crc      <= n_crc;
            r_div      <= n_div;
            r_await    <= n_await;
            r_rx_shift <= n_rx_shift;
            r_gap      <= n_gap;
            r_pos      <= n_pos;
            r_drv_en   <= n_drv_en;
            r_drv_lvl  <= n_drv_lvl;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/swurp_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swurp_out
// Result register: holds one result until the downstream transfer and lets a
// new tick in whenever the register is empty or being emptied.
// ----------------------------------------------------------------------------
module swurp_out
    import swurp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_out_ready,
    output logic         o_space,
    output logic         o_out_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/single_wire_uart_register_poller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// single_wire_uart_register_poller
// Half-duplex single-wire uart master that polls a list of register
// addresses and returns the reply bytes.
// ----------------------------------------------------------------------------
// Each input transfer is one tick carrying the sampled line level; each tick
// gives exactly one output transfer with the line drive, any completed reply
// byte and the reply and sweep flags. A tick is taken every cycle the result
// register is free or being emptied, so throughput is one tick per cycle and
// the result, formed combinationally from the tick and the poller state, is
// registered and appears in the cycle after its input transfer. Configuration
// writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module single_wire_uart_register_poller
    import swurp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_line_in,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_line_drive_enable,
    output logic                        o_line_level,
    output logic                        o_rx_byte_valid,
    output logic [7:0]                  o_rx_byte,
    output logic                        o_reply_done,
    output logic                        o_sweep_done,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [C_LIST_W-1:0]    i_cfg_data
);

    t_cfg    w_cfg;
    t_result w_core_res;
    t_result w_out_res;
    logic    w_space;
    logic    w_tick;

    assign o_in_ready = w_space;
    assign w_tick     = i_in_valid && w_space;

    swurp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    swurp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_tick),
        .i_sample (i_line_in),
        .i_cfg    (w_cfg),
        .o_result (w_core_res)
    );

    swurp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_tick),
        .i_result    (w_core_res),
        .i_out_ready (i_out_ready),
        .o_space     (w_space),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_res)
    );

    assign o_line_drive_enable = w_out_res.line_drive_enable;
    assign o_line_level        = w_out_res.line_level;
    assign o_rx_byte_valid     = w_out_res.rx_byte_valid;
    assign o_rx_byte           = w_out_res.rx_byte;
    assign o_reply_done        = w_out_res.reply_done;
    assign o_sweep_done        = w_out_res.sweep_done;

endmodule
`default_nettype wire

// ===== rtl/swurp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swurp_checker
// Port-level checks of the poller, bound to the top level.
// ----------------------------------------------------------------------------
module swurp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_line_drive_enable,
    input wire logic       o_line_level,
    input wire logic       o_rx_byte_valid,
    input wire logic [7:0] o_rx_byte,
    input wire logic       o_reply_done,
    input wire logic       o_sweep_done
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rx_byte)
            && $stable(o_line_level) && $stable(o_line_drive_enable))
        else $error("result changed while stalled");

    // a free result register always takes a tick
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("tick refused with empty result register");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rx_byte_valid |-> o_rx_byte == 8'd0)
        else $error("reply byte not cleared");

    // reception only happens with the line released
    a_rx_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rx_byte_valid |-> !o_line_drive_enable)
        else $error("reply byte while driving");

    a_flag_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sweep_done |-> o_reply_done && o_rx_byte_valid)
        else $error("sweep end without reply end");

endmodule

bind single_wire_uart_register_poller swurp_checker u_swurp_checker (.*);

`default_nettype wire
